### hdl/fac_pkg.sv
package fac_pkg;

	typedef enum logic [2:0] {
		OP_ATOM,
		OP_OPEN,
		OP_CLOSE,
		OP_PLUS,
		OP_MINUS,
		OP_DIGIT,
		OP_BAD
	} fac_op_t;

	typedef struct packed {
		fac_op_t    op;
		logic [1:0] atom;
		logic [3:0] digit;
		logic       last;
	} fac_word_t;

	localparam logic [1:0] ATOM_C    = 2'd0;
	localparam logic [1:0] ATOM_H    = 2'd1;
	localparam logic [1:0] ATOM_O    = 2'd2;
	localparam logic [1:0] ATOM_SITE = 2'd3;

	localparam logic [2:0] PREV_GROUP = 3'd4;
	localparam logic [2:0] PREV_NONE  = 3'd7;

	localparam logic [7:0] SYM_C     = 8'h43;
	localparam logic [7:0] SYM_H     = 8'h48;
	localparam logic [7:0] SYM_O     = 8'h4F;
	localparam logic [7:0] SYM_SITE  = 8'h2A;
	localparam logic [7:0] SYM_OPEN  = 8'h28;
	localparam logic [7:0] SYM_CLOSE = 8'h29;
	localparam logic [7:0] SYM_PLUS  = 8'h2B;
	localparam logic [7:0] SYM_MINUS = 8'h2D;
	localparam logic [7:0] SYM_ZERO  = 8'h30;
	localparam logic [7:0] SYM_NINE  = 8'h39;

	localparam logic signed [7:0] CHARGE_MAX = 8'sd127;
	localparam logic signed [7:0] CHARGE_MIN = -8'sd128;

endpackage

### hdl/fac_front.sv
module fac_front (
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            symbol,
	input  logic                  final_char,
	input  logic                  q_full,
	output logic                  q_push,
	output fac_pkg::fac_word_t    q_word
);

	logic [7:0] digit_off;

	assign in_stall  = q_full;
	assign q_push    = in_valid && !q_full;
	assign digit_off = symbol - fac_pkg::SYM_ZERO;

	always_comb begin
		q_word.op    = fac_pkg::OP_BAD;
		q_word.atom  = fac_pkg::ATOM_C;
		q_word.digit = digit_off[3:0];
		q_word.last  = final_char;
		case (symbol)
			fac_pkg::SYM_C: begin
				q_word.op   = fac_pkg::OP_ATOM;
				q_word.atom = fac_pkg::ATOM_C;
			end
			fac_pkg::SYM_H: begin
				q_word.op   = fac_pkg::OP_ATOM;
				q_word.atom = fac_pkg::ATOM_H;
			end
			fac_pkg::SYM_O: begin
				q_word.op   = fac_pkg::OP_ATOM;
				q_word.atom = fac_pkg::ATOM_O;
			end
			fac_pkg::SYM_SITE: begin
				q_word.op   = fac_pkg::OP_ATOM;
				q_word.atom = fac_pkg::ATOM_SITE;
			end
			fac_pkg::SYM_OPEN:  q_word.op = fac_pkg::OP_OPEN;
			fac_pkg::SYM_CLOSE: q_word.op = fac_pkg::OP_CLOSE;
			fac_pkg::SYM_PLUS:  q_word.op = fac_pkg::OP_PLUS;
			fac_pkg::SYM_MINUS: q_word.op = fac_pkg::OP_MINUS;
			default: begin
				if (symbol inside {[fac_pkg::SYM_ZERO:fac_pkg::SYM_NINE]}) begin
					q_word.op = fac_pkg::OP_DIGIT;
				end
			end
		endcase
	end

endmodule

### hdl/fac_queue.sv
module fac_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  fac_pkg::fac_word_t push_word,
	output logic               full,
	output logic               head_valid,
	output fac_pkg::fac_word_t head_word,
	input  logic               pop
);

	fac_pkg::fac_word_t mem_q [2];
	logic [1:0]         count_q;
	logic               wr_q;
	logic               rd_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_word  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_word;
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 2'd1)
		else $error("queue count did not grow on push");
`endif

endmodule

### hdl/fac_back.sv
module fac_back #(
	parameter int COUNT_BITS = 10
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     head_valid,
	input  fac_pkg::fac_word_t       head_word,
	output logic                     pop,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [9:0]               carbon_total,
	output logic [9:0]               hydrogen_total,
	output logic [9:0]               oxygen_total,
	output logic [9:0]               site_total,
	output logic signed [7:0]        net_charge,
	output logic signed [13:0]       reduction_number,
	output logic                     bad_symbol
);

	localparam int PW = COUNT_BITS + 5;
	localparam int SW = COUNT_BITS + 6;
	localparam int OW = (COUNT_BITS > 10) ? COUNT_BITS : 10;
	localparam int RW = (COUNT_BITS + 4 > 14) ? COUNT_BITS + 4 : 14;
	localparam logic signed [SW-1:0] SAT_MAX = SW'({COUNT_BITS{1'b1}});
	localparam logic signed [PW-1:0] ONE     = PW'(1);

	logic [COUNT_BITS-1:0] tot_q [4];
	logic [COUNT_BITS-1:0] grp_q [4];
	logic [COUNT_BITS-1:0] tot_d [4];
	logic [COUNT_BITS-1:0] grp_d [4];
	logic signed [PW-1:0]  prod [4];
	logic signed [7:0]     charge_q;
	logic signed [7:0]     charge_d;
	logic                  inside_q;
	logic                  inside_d;
	logic [2:0]            prev_q;
	logic [2:0]            prev_d;
	logic                  err_q;
	logic                  err_d;
	logic signed [4:0]     mult;
	logic signed [PW-1:0]  mult_w;
	logic [1:0]            pa;

	logic                  out_valid_q;
	logic [COUNT_BITS-1:0] out_tot_q [4];
	logic signed [7:0]     out_charge_q;
	logic                  out_err_q;

	logic [OW-1:0]         c_ext;
	logic [OW-1:0]         h_ext;
	logic [OW-1:0]         o_ext;
	logic [OW-1:0]         s_ext;
	logic signed [RW-1:0]  red_w;

	function automatic logic [COUNT_BITS-1:0] sat_add(
		input logic [COUNT_BITS-1:0] base,
		input logic signed [PW-1:0]  delta
	);
		logic signed [SW-1:0] v;
		v = signed'(SW'(base)) + SW'(delta);
		if (v < 0) begin
			sat_add = '0;
		end else if (v > SAT_MAX) begin
			sat_add = '1;
		end else begin
			sat_add = v[COUNT_BITS-1:0];
		end
	endfunction

	assign pop    = head_valid && (!head_word.last || !out_valid_q || !out_stall);
	assign mult   = signed'({1'b0, head_word.digit}) - 5'sd1;
	assign mult_w = PW'(mult);
	assign pa     = prev_q[1:0];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			prod[i] = PW'(signed'({1'b0, grp_q[i]})) * mult_w;
		end
	end

	always_comb begin
		tot_d    = tot_q;
		grp_d    = grp_q;
		charge_d = charge_q;
		inside_d = inside_q;
		prev_d   = prev_q;
		err_d    = err_q;
		case (head_word.op)
			fac_pkg::OP_ATOM: begin
				tot_d[head_word.atom] = sat_add(tot_q[head_word.atom], ONE);
				if (inside_q) begin
					grp_d[head_word.atom] = sat_add(grp_q[head_word.atom], ONE);
				end
				prev_d = {1'b0, head_word.atom};
			end
			fac_pkg::OP_OPEN: begin
				inside_d = 1'b1;
				for (int i = 0; i < 4; i++) begin
					grp_d[i] = '0;
				end
			end
			fac_pkg::OP_CLOSE: begin
				inside_d = 1'b0;
				prev_d   = fac_pkg::PREV_GROUP;
			end
			fac_pkg::OP_PLUS: begin
				if (charge_q != fac_pkg::CHARGE_MAX) begin
					charge_d = charge_q + 8'sd1;
				end
			end
			fac_pkg::OP_MINUS: begin
				if (charge_q != fac_pkg::CHARGE_MIN) begin
					charge_d = charge_q - 8'sd1;
				end
			end
			fac_pkg::OP_DIGIT: begin
				if (prev_q == fac_pkg::PREV_GROUP) begin
					for (int i = 0; i < 4; i++) begin
						tot_d[i] = sat_add(tot_q[i], prod[i]);
						grp_d[i] = '0;
					end
				end else if (!prev_q[2]) begin
					tot_d[pa] = sat_add(tot_q[pa], mult_w);
					if (inside_q) begin
						grp_d[pa] = sat_add(grp_q[pa], mult_w);
					end
				end
			end
			fac_pkg::OP_BAD: err_d = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				tot_q[i] <= '0;
				grp_q[i] <= '0;
			end
			charge_q    <= '0;
			inside_q    <= 1'b0;
			prev_q      <= fac_pkg::PREV_NONE;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && head_word.last) begin
				for (int i = 0; i < 4; i++) begin
					tot_q[i] <= '0;
					grp_q[i] <= '0;
				end
				charge_q    <= '0;
				inside_q    <= 1'b0;
				prev_q      <= fac_pkg::PREV_NONE;
				err_q       <= 1'b0;
				out_valid_q <= 1'b1;
			end else begin
				if (pop) begin
					tot_q    <= tot_d;
					grp_q    <= grp_d;
					charge_q <= charge_d;
					inside_q <= inside_d;
					prev_q   <= prev_d;
					err_q    <= err_d;
				end
				if (!out_stall) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_word.last) begin
			out_tot_q    <= tot_d;
			out_charge_q <= charge_d;
			out_err_q    <= err_d;
		end
	end

	assign c_ext = OW'(out_tot_q[fac_pkg::ATOM_C]);
	assign h_ext = OW'(out_tot_q[fac_pkg::ATOM_H]);
	assign o_ext = OW'(out_tot_q[fac_pkg::ATOM_O]);
	assign s_ext = OW'(out_tot_q[fac_pkg::ATOM_SITE]);

	// h - 2o + 4c, kept to the low bits of the result word
	assign red_w = signed'(RW'(out_tot_q[fac_pkg::ATOM_H]))
		- signed'(RW'({out_tot_q[fac_pkg::ATOM_O], 1'b0}))
		+ signed'(RW'({out_tot_q[fac_pkg::ATOM_C], 2'b00}));

	assign out_valid        = out_valid_q;
	assign carbon_total     = c_ext[9:0];
	assign hydrogen_total   = h_ext[9:0];
	assign oxygen_total     = o_ext[9:0];
	assign site_total       = s_ext[9:0];
	assign net_charge       = out_charge_q;
	assign reduction_number = red_w[13:0];
	assign bad_symbol       = out_err_q;

`ifndef ASSERT_OFF
	a_last_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head_word.last) |=> out_valid_q)
		else $error("final word did not load the result register");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head_word.last) |=>
			(charge_q == 8'sd0 && !inside_q && !err_q && prev_q == fac_pkg::PREV_NONE))
		else $error("state not cleared after final word");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !(pop && head_word.last))
		else $error("held result overwritten");
`endif

endmodule

### hdl/formula_atom_counter.sv
// Formula atom counter: takes a species formula one character per word and, on the
// word marked final_char, returns the C, H, O and site counts, net charge, the
// reduction number h - 2o + 4c and a flag for unknown characters; state then
// clears for the next formula. One character is taken every cycle unless a full
// queue raises in_stall; the result register is loaded when the final character
// is popped from the queue. The back end sets the rate, updating the running
// counts, including the group digit multiply, per character popped; a two-word
// queue sits between the character decoder and the back end, and the result
// register lets characters of the next formula keep flowing while a result waits.
module formula_atom_counter #(
	parameter int COUNT_BITS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         symbol,
	input  logic               final_char,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [9:0]         carbon_total,
	output logic [9:0]         hydrogen_total,
	output logic [9:0]         oxygen_total,
	output logic [9:0]         site_total,
	output logic signed [7:0]  net_charge,
	output logic signed [13:0] reduction_number,
	output logic               bad_symbol
);

	logic               q_full;
	logic               q_push;
	fac_pkg::fac_word_t q_word;
	logic               head_valid;
	fac_pkg::fac_word_t head_word;
	logic               q_pop;

	fac_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.symbol     (symbol),
		.final_char (final_char),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_word     (q_word)
	);

	fac_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_word  (q_word),
		.full       (q_full),
		.head_valid (head_valid),
		.head_word  (head_word),
		.pop        (q_pop)
	);

	fac_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head_valid       (head_valid),
		.head_word        (head_word),
		.pop              (q_pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.carbon_total     (carbon_total),
		.hydrogen_total   (hydrogen_total),
		.oxygen_total     (oxygen_total),
		.site_total       (site_total),
		.net_charge       (net_charge),
		.reduction_number (reduction_number),
		.bad_symbol       (bad_symbol)
	);

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int COUNT_MAX     = 1023;
	localparam int STALL_PCT     = 34;
	localparam int HANG_LIMIT    = 4000;
	localparam int SETTLE_CYCLES = 20;

	typedef struct {
		logic [9:0]         carbon;
		logic [9:0]         hydrogen;
		logic [9:0]         oxygen;
		logic [9:0]         sites;
		logic signed [7:0]  charge;
		logic signed [13:0] reduction;
		logic               bad;
	} formula_totals_t;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               in_valid   = 1'b0;
	logic               in_stall;
	logic [7:0]         symbol     = 8'h00;
	logic               final_char = 1'b0;
	logic               out_valid;
	logic               out_stall  = 1'b0;
	logic [9:0]         carbon_total;
	logic [9:0]         hydrogen_total;
	logic [9:0]         oxygen_total;
	logic [9:0]         site_total;
	logic signed [7:0]  net_charge;
	logic signed [13:0] reduction_number;
	logic               bad_symbol;

	formula_totals_t awaited_totals[$];
	logic [7:0]      formula_chars[$];
	int              error_count = 0;
	int              hang_cycles = 0;
	bit              sender_idles = 1'b1;
	bit              receiver_stalls = 1'b1;

	// running counts of the formula being read
	int         elem_count[4];
	int         group_count[4];
	int         charge_sum;
	bit         in_group;
	logic [2:0] prev_atom;
	bit         saw_bad;

	formula_atom_counter u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.symbol           (symbol),
		.final_char       (final_char),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.carbon_total     (carbon_total),
		.hydrogen_total   (hydrogen_total),
		.oxygen_total     (oxygen_total),
		.site_total       (site_total),
		.net_charge       (net_charge),
		.reduction_number (reduction_number),
		.bad_symbol       (bad_symbol)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int clamp_count(int v);
		if (v < 0)
			return 0;
		if (v > COUNT_MAX)
			return COUNT_MAX;
		return v;
	endfunction

	task automatic clear_formula();
		for (int i = 0; i < 4; i++) begin
			elem_count[i] = 0;
			group_count[i] = 0;
		end
		charge_sum = 0;
		in_group = 1'b0;
		prev_atom = fac_pkg::PREV_NONE;
		saw_bad = 1'b0;
	endtask

	task automatic add_atom(input logic [1:0] a);
		elem_count[a] = clamp_count(elem_count[a] + 1);
		if (in_group)
			group_count[a] = clamp_count(group_count[a] + 1);
		prev_atom = {1'b0, a};
	endtask

	task automatic count_symbol(input logic [7:0] sym, input logic last);
		int mult;
		formula_totals_t t;
		case (sym)
			fac_pkg::SYM_C:     add_atom(fac_pkg::ATOM_C);
			fac_pkg::SYM_H:     add_atom(fac_pkg::ATOM_H);
			fac_pkg::SYM_O:     add_atom(fac_pkg::ATOM_O);
			fac_pkg::SYM_SITE:  add_atom(fac_pkg::ATOM_SITE);
			fac_pkg::SYM_OPEN: begin
				in_group = 1'b1;
				for (int i = 0; i < 4; i++)
					group_count[i] = 0;
			end
			fac_pkg::SYM_CLOSE: begin
				in_group = 1'b0;
				prev_atom = fac_pkg::PREV_GROUP;
			end
			fac_pkg::SYM_PLUS: begin
				if (charge_sum < fac_pkg::CHARGE_MAX)
					charge_sum++;
			end
			fac_pkg::SYM_MINUS: begin
				if (charge_sum > fac_pkg::CHARGE_MIN)
					charge_sum--;
			end
			default: begin
				if (sym >= fac_pkg::SYM_ZERO && sym <= fac_pkg::SYM_NINE) begin
					mult = int'(sym) - int'(fac_pkg::SYM_ZERO) - 1;
					if (prev_atom == fac_pkg::PREV_GROUP) begin
						for (int i = 0; i < 4; i++) begin
							elem_count[i] =
								clamp_count(elem_count[i] + group_count[i] * mult);
							group_count[i] = 0;
						end
					end else if (prev_atom < fac_pkg::PREV_GROUP) begin
						elem_count[prev_atom[1:0]] =
							clamp_count(elem_count[prev_atom[1:0]] + mult);
						if (in_group)
							group_count[prev_atom[1:0]] =
								clamp_count(group_count[prev_atom[1:0]] + mult);
					end
				end else begin
					saw_bad = 1'b1;
				end
			end
		endcase
		if (last) begin
			t.carbon = 10'(elem_count[fac_pkg::ATOM_C]);
			t.hydrogen = 10'(elem_count[fac_pkg::ATOM_H]);
			t.oxygen = 10'(elem_count[fac_pkg::ATOM_O]);
			t.sites = 10'(elem_count[fac_pkg::ATOM_SITE]);
			t.charge = 8'(charge_sum);
			t.reduction = 14'(elem_count[fac_pkg::ATOM_H]
				- 2 * elem_count[fac_pkg::ATOM_O]
				+ 4 * elem_count[fac_pkg::ATOM_C]);
			t.bad = saw_bad;
			awaited_totals.push_back(t);
			clear_formula();
		end
	endtask

	task automatic send_word(input logic [7:0] sym, input logic last);
		bit taken;
		while (sender_idles && $urandom_range(99) < STALL_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		symbol <= sym;
		final_char <= last;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		count_symbol(sym, last);
	endtask

	task automatic send_formula();
		foreach (formula_chars[i])
			send_word(formula_chars[i], i == formula_chars.size() - 1);
		formula_chars.delete();
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			formula_chars.push_back(s[i]);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited_totals.size() != 0)
			@(posedge clk);
	endtask

	task automatic push_atom();
		logic [7:0] atoms[4];
		atoms = '{fac_pkg::SYM_C, fac_pkg::SYM_H, fac_pkg::SYM_O, fac_pkg::SYM_SITE};
		formula_chars.push_back(atoms[$urandom_range(3)]);
		if ($urandom_range(1))
			formula_chars.push_back(8'(fac_pkg::SYM_ZERO + $urandom_range(9)));
	endtask

	task automatic build_random_formula();
		int pick;
		if ($urandom_range(9) == 0) begin
			// raw noise
			repeat ($urandom_range(8, 1))
				formula_chars.push_back(8'($urandom));
		end else begin
			repeat ($urandom_range(6, 1)) begin
				pick = $urandom_range(19);
				if (pick < 10) begin
					push_atom();
				end else if (pick < 14) begin
					formula_chars.push_back(fac_pkg::SYM_OPEN);
					repeat ($urandom_range(3, 1))
						push_atom();
					formula_chars.push_back(fac_pkg::SYM_CLOSE);
					if ($urandom_range(9) < 7)
						formula_chars.push_back(8'(fac_pkg::SYM_ZERO + $urandom_range(9)));
				end else if (pick < 16) begin
					repeat ($urandom_range(3, 1))
						formula_chars.push_back($urandom_range(1) ?
							fac_pkg::SYM_PLUS : fac_pkg::SYM_MINUS);
				end else if (pick == 16) begin
					formula_chars.push_back(8'($urandom));
				end else if (pick == 17) begin
					formula_chars.push_back(8'(fac_pkg::SYM_ZERO + $urandom_range(9)));
				end else begin
					formula_chars.push_back($urandom_range(1) ?
						fac_pkg::SYM_OPEN : fac_pkg::SYM_CLOSE);
				end
			end
		end
	endtask

	task automatic test_directed();
		push_text("5C(H2)3+");
		send_formula();
		push_text("O00)9-");
		formula_chars.push_back(8'h00);
		send_formula();
		push_text("C(*2)24");
		formula_chars.push_back(8'hFF);
		send_formula();
		wait_drained();
	endtask

	task automatic test_saturation();
		repeat (13) push_text("(CH*9)9");
		repeat (130) push_text("-");
		send_formula();
		repeat (13) push_text("(O9)9");
		repeat (130) push_text("+");
		send_formula();
		// step down from the ceiling
		repeat (13) push_text("(H9)9");
		push_text("H0");
		send_formula();
		wait_drained();
	endtask

	task automatic test_random(input int budget);
		int sent;
		sent = 0;
		while (sent < budget) begin
			build_random_formula();
			sent += formula_chars.size();
			send_formula();
		end
		wait_drained();
	endtask

	task automatic test_random_steady();
		sender_idles = 1'b0;
		receiver_stalls = 1'b0;
		test_random(300);
		sender_idles = 1'b1;
		receiver_stalls = 1'b1;
	endtask

	task automatic test_random_mixed();
		test_random(600);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s expected %0d got %0d", name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk)
		out_stall <= receiver_stalls && ($urandom_range(99) < STALL_PCT);

	always @(negedge clk) begin
		formula_totals_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (awaited_totals.size() == 0) begin
					$error("result word with no formula pending");
					error_count++;
				end else begin
					want = awaited_totals.pop_front();
					check_field("carbon_total", want.carbon, carbon_total);
					check_field("hydrogen_total", want.hydrogen, hydrogen_total);
					check_field("oxygen_total", want.oxygen, oxygen_total);
					check_field("site_total", want.sites, site_total);
					check_field("net_charge", want.charge, net_charge);
					check_field("reduction_number", want.reduction, reduction_number);
					check_field("bad_symbol", want.bad, bad_symbol);
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				hang_cycles = 0;
			end else begin
				hang_cycles++;
				if (hang_cycles >= HANG_LIMIT) begin
					$display("testbench: errors");
					$finish;
				end
			end
		end
	end

	initial begin
		clear_formula();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_saturation();
		test_random_steady();
		test_random_mixed();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
